// ===== rtl/core/dtse_pkg.sv =====
// ----------------------------------------------------------------------------
// dtse_pkg
// Types, command and field codes, and calendar helpers for the clock-setting
// editor.
// ----------------------------------------------------------------------------
package dtse_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_ADJUST = 3'd0,
    CMD_MOVE   = 3'd1,
    CMD_SELECT = 3'd2,
    CMD_LOAD   = 3'd3,
    CMD_COMMIT = 3'd4
  } dtse_cmd_t;

  // Field codes (code 3 is the weekday, which is never edited)
  localparam logic [2:0] FLD_MINUTE = 3'd1;
  localparam logic [2:0] FLD_HOUR   = 3'd2;
  localparam logic [2:0] FLD_DAY    = 3'd4;
  localparam logic [2:0] FLD_MONTH  = 3'd5;
  localparam logic [2:0] FLD_YEAR   = 3'd6;
  localparam logic [2:0] FLD_SKIP   = 3'd3;

  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [5:0] HOUR_MAX   = 6'd23;
  localparam logic [5:0] MONTH_MAX  = 6'd12;
  localparam logic [5:0] YEAR_MAX   = 6'd38;   // 2038, counted from 2000
  localparam logic [5:0] DAY_DFLT   = 6'd31;   // month code out of range

  // Year codes are years since 1970; the editor shows years since 2000.
  localparam int         EPOCH_YEAR  = 1970;
  localparam logic [7:0] YEAR_OFFSET = 8'(2000 - EPOCH_YEAR);
  localparam logic [7:0] YEAR_2100   = 8'(2100 - EPOCH_YEAR);
  localparam logic [7:0] YEAR_2200   = 8'(2200 - EPOCH_YEAR);

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;    // years since 1970
  } dtse_time_t;

  typedef struct packed {
    logic signed [8:0] value;
    logic              lower;   // lower bound is 0 or 1
    logic [5:0]        upper;
  } dtse_work_t;

  typedef struct packed {
    dtse_time_t tm;
    logic [2:0] field;
    dtse_work_t work;
  } dtse_state_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic signed [7:0] amount;
    logic [2:0]        field_sel;
    dtse_time_t        load;
  } dtse_item_t;

  localparam dtse_state_t STATE_RESET = '{
    tm:    '{sec: 6'd0, min: 6'd0, hour: 5'd12, day: 5'd1, month: 4'd1,
             year: 8'd31},
    field: FLD_YEAR,
    work:  '{value: 9'sd1, lower: 1'b0, upper: YEAR_MAX}
  };

  // Gregorian rule on year + 1970 over 1970..2225: divisible by four means
  // code mod 4 == 2; 2000 is leap, 2100 and 2200 are not.
  function automatic logic is_leap(logic [7:0] year);
    return (year[1:0] == 2'b10) && (year != YEAR_2100) && (year != YEAR_2200);
  endfunction

  function automatic logic [5:0] day_limit(logic [3:0] month, logic [7:0] year);
    logic [5:0] lim;
    if (month >= 4'd1 && month <= 4'd12) begin
      lim = {1'b0, MONTH_DAYS[4'(month - 4'd1)]};
      if (month == 4'd2 && is_leap(year)) begin
        lim = lim + 6'd1;
      end
    end else begin
      lim = DAY_DFLT;
    end
    return lim;
  endfunction

  // Load the working copy and bounds of a field from the time.
  function automatic dtse_work_t fetch_field(logic [2:0] field, dtse_time_t tm,
                                             dtse_work_t prev);
    dtse_work_t w;
    w = prev;
    case (field)
      FLD_MINUTE: w = '{value: $signed({3'b0, tm.min}), lower: 1'b0,
                        upper: MINUTE_MAX};
      FLD_HOUR:   w = '{value: $signed({4'b0, tm.hour}), lower: 1'b0,
                        upper: HOUR_MAX};
      FLD_DAY:    w = '{value: $signed({4'b0, tm.day}), lower: 1'b1,
                        upper: day_limit(tm.month, tm.year)};
      FLD_MONTH:  w = '{value: $signed({5'b0, tm.month}), lower: 1'b1,
                        upper: MONTH_MAX};
      FLD_YEAR:   w = '{value: $signed({1'b0, tm.year} - {1'b0, YEAR_OFFSET}),
                        lower: 1'b0, upper: YEAR_MAX};
      default:    w = prev;
    endcase
    return w;
  endfunction

  // Store the working copy back into its field, truncated to width.
  function automatic dtse_time_t write_back(logic [2:0] field,
                                            logic signed [8:0] value,
                                            dtse_time_t tm);
    dtse_time_t t;
    t = tm;
    case (field)
      FLD_MINUTE: t.min   = value[5:0];
      FLD_HOUR:   t.hour  = value[4:0];
      FLD_DAY:    t.day   = value[4:0];
      FLD_MONTH:  t.month = value[3:0];
      FLD_YEAR:   t.year  = value[7:0] + YEAR_OFFSET;
      default:    t = tm;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/dtse_next.sv =====
// ----------------------------------------------------------------------------
// dtse_next
// Next-state logic of the editor: one command applied to the held state.
// ----------------------------------------------------------------------------
module dtse_next
  import dtse_pkg::*;
(
  input  dtse_state_t cur,
  input  dtse_item_t  item,
  output dtse_state_t nxt
);

  logic signed [9:0] sum;
  logic signed [9:0] lo;
  logic signed [9:0] hi;
  logic signed [9:0] tgt;
  logic signed [9:0] amt;
  logic [2:0]        new_field;
  dtse_time_t        wb_time;

  assign amt = {{2{item.amount[7]}}, item.amount};

  // Adjust: add and clamp
  always_comb begin
    sum = {cur.work.value[8], cur.work.value} + amt;
    lo  = $signed({9'b0, cur.work.lower});
    hi  = $signed({4'b0, cur.work.upper});
  end

  // Move target: skip the weekday, wrap between minute and year
  always_comb begin
    tgt = $signed({7'b0, cur.field}) + amt;
    if (tgt == $signed({7'b0, FLD_SKIP})) begin
      tgt = item.amount[7] ? tgt - 10'sd1 : tgt + 10'sd1;
    end
    if (tgt < $signed({7'b0, FLD_MINUTE})) begin
      tgt = $signed({7'b0, FLD_YEAR});
    end else if (tgt > $signed({7'b0, FLD_YEAR})) begin
      tgt = $signed({7'b0, FLD_MINUTE});
    end
  end

  assign wb_time = write_back(cur.field, cur.work.value, cur.tm);

  always_comb begin
    nxt       = cur;
    new_field = cur.field;
    case (item.cmd)
      CMD_ADJUST: begin
        if (sum < lo) begin
          nxt.work.value = lo[8:0];
        end else if (sum > hi) begin
          nxt.work.value = hi[8:0];
        end else begin
          nxt.work.value = sum[8:0];
        end
      end
      CMD_MOVE, CMD_SELECT: begin
        if (item.cmd == CMD_MOVE) begin
          new_field = tgt[2:0];
        end else if (item.field_sel inside {FLD_MINUTE, FLD_HOUR, FLD_DAY,
                                            FLD_MONTH, FLD_YEAR}) begin
          new_field = item.field_sel;
        end
        nxt.tm    = wb_time;
        nxt.field = new_field;
        nxt.work  = fetch_field(new_field, wb_time, cur.work);
      end
      CMD_LOAD: begin
        nxt.tm   = item.load;
        nxt.work = fetch_field(cur.field, item.load, cur.work);
      end
      CMD_COMMIT: begin
        nxt.tm = wb_time;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== rtl/core/date_time_setting_editor.sv =====
// ----------------------------------------------------------------------------
// date_time_setting_editor
// Clock-setting editor: holds a calendar time and edits one field at a time.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Signals                    Carries
// s_       in   tvalid tready tdata tuser  one edit command, its step and time
// m_       out  tvalid tready tdata        the stored time and edit state
//
// One result item for every input item, in order.
// Throughput: one item per cycle while m_ is not stalled. An accepted item passes
//   the input register, then the next-state logic into the state/result register.
// Reset (rst, synchronous) drops both valid flags and loads the power-on time
//   12:00:00, Jan 1 2001, with the year under edit.
// A stalled m_ side holds its item; the input register still takes one more
//   item, after which s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module date_time_setting_editor
  import dtse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] amount (signed), [10:8] field_sel, [16:11] second_in,
  // [22:17] minute_in, [27:23] hour_in, [32:28] day_in, [36:33] month_in,
  // [44:37] year_in, [47:45] zero
  input  logic [47:0] s_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_tuser,

  output logic        m_tvalid,
  input  logic        m_tready,
  // [5:0] sec_out, [11:6] min_out, [16:12] hour_out, [21:17] day_out,
  // [25:22] month_out, [33:26] year_out, [36:34] field_out,
  // [45:37] work_value (signed), [47:46] zero
  output logic [47:0] m_tdata
);

  dtse_item_t  item;
  logic        in_valid;
  logic        advance;
  dtse_state_t state;
  dtse_state_t state_next;

  // The held item moves on when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.cmd        <= s_tuser;
      item.amount     <= $signed(s_tdata[7:0]);
      item.field_sel  <= s_tdata[10:8];
      item.load.sec   <= s_tdata[16:11];
      item.load.min   <= s_tdata[22:17];
      item.load.hour  <= s_tdata[27:23];
      item.load.day   <= s_tdata[32:28];
      item.load.month <= s_tdata[36:33];
      item.load.year  <= s_tdata[44:37];
    end
  end

  dtse_next u_next (
    .cur  (state),
    .item (item),
    .nxt  (state_next)
  );

  // Edit state: time, field under edit, working copy and bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b0, state_next.work.value, state_next.field,
                  state_next.tm.year, state_next.tm.month, state_next.tm.day,
                  state_next.tm.hour, state_next.tm.min, state_next.tm.sec};
    end
  end

  // After an adjust the working copy sits inside its bounds
  a_adjust_clamped: assert property (@(posedge clk) disable iff (rst)
    advance && (item.cmd == CMD_ADJUST) |=>
      (state.work.value >= $signed({9'b0, state.work.lower})) &&
      (state.work.value <= $signed({4'b0, state.work.upper})))
    else $error("working copy outside bounds after adjust");

  // The weekday and unused codes are never under edit
  a_field_legal: assert property (@(posedge clk) disable iff (rst)
    !(state.field == 3'd0 || state.field == FLD_SKIP || state.field == 3'd7))
    else $error("illegal field under edit");

  // State only changes when an item is applied
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");

  // Input stalls only when both registers are full and output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without cause");

  // A blocked result holds its data
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result lost");

endmodule
